@@ sv/dcd_pkg.sv @@
// Shared types and constants for the delta command decoder.
// Used by every module of the block; depends on nothing else.
package dcd_pkg;

   localparam int unsigned StreamLengthWidth = 24;
   localparam int unsigned ConsumedWidth     = 25;
   localparam int unsigned CountWidth        = 15;
   localparam int unsigned PositionWidth     = 32;
   localparam int unsigned PieceWidth        = 16;

   localparam logic [CountWidth-1:0]    LENGTH_MASK    = 15'h7fff;
   localparam logic [PieceWidth-1:0]    COPY_BIAS      = 16'd6;
   localparam logic [ConsumedWidth-1:0] CONSUMED_LIMIT = 25'h1ffffff;

   localparam logic [2:0] PHASE_HEADER_LOW  = 3'd0;
   localparam logic [2:0] PHASE_HEADER_HIGH = 3'd1;
   localparam logic [2:0] PHASE_OFFSET_0    = 3'd2;
   localparam logic [2:0] PHASE_OFFSET_1    = 3'd3;
   localparam logic [2:0] PHASE_OFFSET_2    = 3'd4;
   localparam logic [2:0] PHASE_OFFSET_3    = 3'd5;
   localparam logic [2:0] PHASE_LITERAL     = 3'd6;

   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_COPY    = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   typedef struct packed {
      logic [1:0]               kind;
      logic [7:0]               literal_byte;
      logic [31:0]              copy_offset;
      logic [PieceWidth-1:0]    piece_length;
      logic [PositionWidth-1:0] out_position;
      logic                     last;
   } result_type;

endpackage

@@ sv/dcd_in_stage.sv @@
// Input register of the delta command decoder.
// Holds one command-stream byte until the parser can take it; uses dcd_pkg.
module dcd_in_stage
   import dcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_value
);

   logic       valid_ff;
   logic [7:0] byte_ff;

   assign req_stall  = valid_ff && !advance;
   assign byte_valid = valid_ff;
   assign byte_value = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff <= req_data_byte;
      end
   end

endmodule

@@ sv/dcd_parser.sv @@
// Parse state and result formation of the delta command decoder.
// Consumes one byte per transaction and forms at most one result; uses dcd_pkg.
module dcd_parser
   import dcd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [7:0]                   data_byte,
   input  logic [StreamLengthWidth-1:0] stream_length,
   output logic                         result_valid,
   output result_type                   result
);

   logic [2:0]               phase_ff, phase_in;
   logic [7:0]               header_low_ff, header_low_in;
   logic [23:0]              offset_ff, offset_in;
   logic [CountWidth-1:0]    literals_left_ff, literals_left_in;
   logic [ConsumedWidth-1:0] consumed_ff, consumed_in;
   logic [PositionWidth-1:0] position_ff, position_in;
   logic                     finished_ff, finished_in;
   logic [15:0]              header;
   logic [CountWidth-1:0]    literals_next;
   logic                     at_end;

   assign header        = {data_byte, header_low_ff};
   assign literals_next = literals_left_ff - 15'd1;

   always_comb begin
      phase_in         = phase_ff;
      header_low_in    = header_low_ff;
      offset_in        = offset_ff;
      literals_left_in = literals_left_ff;
      consumed_in      = consumed_ff;
      position_in      = position_ff;
      finished_in      = finished_ff;
      result_valid     = 1'b0;
      result           = '0;
      result.out_position = position_ff;
      if (consumed_ff < CONSUMED_LIMIT) begin
         consumed_in = consumed_ff + 25'd1;
      end
      at_end = consumed_in >= {1'b0, stream_length};
      if (!fire || finished_ff) begin
         consumed_in = consumed_ff;
      end else begin
         unique case (phase_ff)
            PHASE_HEADER_LOW: begin
               header_low_in = data_byte;
               phase_in      = PHASE_HEADER_HIGH;
            end
            PHASE_HEADER_HIGH: begin
               literals_left_in = header[14:0] & LENGTH_MASK;
               if (header[15]) begin
                  offset_in = '0;
                  phase_in  = PHASE_OFFSET_0;
               end else if (header[14:0] != '0) begin
                  phase_in = PHASE_LITERAL;
               end else begin
                  phase_in = PHASE_HEADER_LOW;
                  if (at_end) begin
                     finished_in  = 1'b1;
                     result_valid = 1'b1;
                     result.kind  = KIND_END;
                     result.last  = 1'b1;
                  end
               end
            end
            PHASE_OFFSET_0: begin
               offset_in[7:0] = data_byte;
               phase_in       = PHASE_OFFSET_1;
            end
            PHASE_OFFSET_1: begin
               offset_in[15:8] = data_byte;
               phase_in        = PHASE_OFFSET_2;
            end
            PHASE_OFFSET_2: begin
               offset_in[23:16] = data_byte;
               phase_in         = PHASE_OFFSET_3;
            end
            PHASE_OFFSET_3: begin
               literals_left_in    = '0;
               phase_in            = PHASE_HEADER_LOW;
               finished_in         = at_end;
               result_valid        = 1'b1;
               result.kind         = KIND_COPY;
               result.copy_offset  = {data_byte, offset_ff};
               result.piece_length = {1'b0, literals_left_ff} + COPY_BIAS;
               result.last         = at_end;
               position_in         = position_ff + {16'd0, result.piece_length};
            end
            PHASE_LITERAL: begin
               literals_left_in     = literals_next;
               result_valid         = 1'b1;
               result.kind          = KIND_LITERAL;
               result.literal_byte  = data_byte;
               result.piece_length  = 16'd1;
               position_in          = position_ff + 32'd1;
               if (literals_next == '0) begin
                  phase_in    = PHASE_HEADER_LOW;
                  finished_in = at_end;
                  result.last = at_end;
               end
            end
            default: begin
               phase_in = PHASE_HEADER_LOW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_HEADER_LOW;
         header_low_ff    <= '0;
         offset_ff        <= '0;
         literals_left_ff <= '0;
         consumed_ff      <= '0;
         position_ff      <= '0;
         finished_ff      <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         header_low_ff    <= header_low_in;
         offset_ff        <= offset_in;
         literals_left_ff <= literals_left_in;
         consumed_ff      <= consumed_in;
         position_ff      <= position_in;
         finished_ff      <= finished_in;
      end
   end

endmodule

@@ sv/dcd_out_stage.sv @@
// Result register of the delta command decoder.
// Holds one result until the receiver takes it; uses dcd_pkg.
module dcd_out_stage
   import dcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  result_type load_result,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   logic       valid_ff;
   result_type result_ff;

   assign advance    = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= load_result;
      end
   end

endmodule

@@ sv/delta_command_decoder.sv @@
// Delta command decoder: takes the command stream one byte per transaction and
// emits literal bytes, copy commands and end markers; uses dcd_pkg.
//
// The block accepts one byte every cycle while the result side keeps up; a
// byte is parsed while it is held in the input register and the result side
// can take it, and its result is then presented from the result register
// until the receiver takes it. Throughput is set by the single parse step
// per byte. Write csr_write_data to set the stream length only while no
// transaction is in flight; after the final command further bytes are
// accepted and dropped until reset.
module delta_command_decoder
   import dcd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [StreamLengthWidth-1:0] csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [7:0]                   rsp_literal_byte,
   output logic [31:0]                  rsp_copy_offset,
   output logic [PieceWidth-1:0]        rsp_piece_length,
   output logic [PositionWidth-1:0]     rsp_out_position,
   output logic                         rsp_last
);

   logic [StreamLengthWidth-1:0] stream_length_ff;
   logic                         advance;
   logic                         byte_valid;
   logic [7:0]                   byte_value;
   logic                         result_valid;
   result_type                   result;
   result_type                   rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= '0;
      end else if (csr_write_enable) begin
         stream_length_ff <= csr_write_data;
      end
   end

   dcd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .byte_valid    (byte_valid),
      .byte_value    (byte_value)
   );

   dcd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (byte_valid && advance),
      .data_byte     (byte_value),
      .stream_length (stream_length_ff),
      .result_valid  (result_valid),
      .result        (result)
   );

   dcd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (result_valid && byte_valid),
      .load_result (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_kind         = rsp_result.kind;
   assign rsp_literal_byte = rsp_result.literal_byte;
   assign rsp_copy_offset  = rsp_result.copy_offset;
   assign rsp_piece_length = rsp_result.piece_length;
   assign rsp_out_position = rsp_result.out_position;
   assign rsp_last         = rsp_result.last;

endmodule
